// ===== rtl/core/mqb_pkg.sv =====
`default_nettype none
package mqb_pkg;

  localparam int unsigned NUM_QUEUES    = 4;
  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned MAX_MSG_BYTES = 64;
  localparam int unsigned SLOT_WORDS    = (MAX_MSG_BYTES + 7) / 8;
  localparam int unsigned TOTAL_SLOTS   = NUM_QUEUES * QUEUE_DEPTH;

  localparam int unsigned QIDX_W  = 2;
  localparam int unsigned DIDX_W  = 4;
  localparam int unsigned SLOT_W  = QIDX_W + DIDX_W;
  localparam int unsigned WIDX_W  = 3;
  localparam int unsigned PADDR_W = SLOT_W + WIDX_W;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned TYPE_W  = 32;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_OPEN = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;

  localparam logic MODE_SEND = 1'b0;
  localparam logic MODE_RECV = 1'b1;

  localparam logic [0:0] REG_OPEN_MASK = 1'b0;

  typedef struct packed {
    logic signed [TYPE_W-1:0] msg_type;
    logic [LEN_W-1:0]         length;
    logic [DIDX_W-1:0]        rank;
  } meta_t;

  localparam int unsigned META_W = $bits(meta_t);

endpackage
`default_nettype wire

// ===== rtl/core/mqb_ram.sv =====
`default_nettype none
module mqb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mqb_cfg.sv =====
`default_nettype none
module mqb_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mqb_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [mqb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [mqb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [mqb_pkg::NUM_QUEUES-1:0]    open_mask_o
);
  import mqb_pkg::*;

  logic [NUM_QUEUES-1:0] mask_q, mask_d;
  logic                  sel_mask;

  assign sel_mask = (paddr[APB_ADDR_W-1] == REG_OPEN_MASK);

  always_comb begin
    mask_d = mask_q;
    if (psel && penable && pwrite && sel_mask) begin
      mask_d = pwdata[NUM_QUEUES-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  assign prdata      = sel_mask ? {{(APB_DATA_W-NUM_QUEUES){1'b0}}, mask_q} : '0;
  assign pready      = 1'b1;
  assign open_mask_o = mask_q;

endmodule
`default_nettype wire

// ===== rtl/core/typed_message_queue_bank.sv =====
// Bank of four typed message queues, 16 messages of up to 64 bytes each.
// A send is a run of beats (mode 0), one payload word per beat; non-final beats
// may follow back to back. The final beat answers with one status result in
// the next cycle, then, if the message was stored, holds busy while the unused
// words of the slot are cleared. A receive (mode 1) scans the 16 slots of its
// queue through the metadata memory, makes a second pass to renumber arrival
// ranks, then streams one result per payload word, up to eight, one per cycle.
// Errors found at the start answer in the next cycle; a failed match answers
// after the scan. Results appear for one cycle under result_valid_o and cannot
// be held off.
`default_nettype none
module typed_message_queue_bank (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mqb_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [mqb_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [mqb_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               mode_i,
  input  wire logic [mqb_pkg::QIDX_W-1:0]         queue_index_i,
  input  wire logic signed [mqb_pkg::TYPE_W-1:0]  msg_type_i,
  input  wire logic [mqb_pkg::LEN_W-1:0]          byte_length_i,
  input  wire logic [mqb_pkg::WORD_W-1:0]         data_word_i,
  input  wire logic                               last_beat_i,
  input  wire logic                               except_flag_i,
  input  wire logic                               truncate_flag_i,
  output logic                                    result_valid_o,
  output logic      [2:0]                         status_o,
  output logic signed [mqb_pkg::TYPE_W-1:0]       out_type_o,
  output logic      [mqb_pkg::LEN_W-1:0]          out_length_o,
  output logic      [mqb_pkg::WORD_W-1:0]         out_word_o,
  output logic                                    last_result_o
);
  import mqb_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FILL     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SCAN_END = 3'd3;
  localparam logic [2:0] S_FIX      = 3'd4;
  localparam logic [2:0] S_FIX_END  = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;
  localparam logic [2:0] S_OUT_END  = 3'd7;

  function automatic logic sel_match(logic signed [TYPE_W-1:0] t,
                                     logic signed [TYPE_W-1:0] sel, logic ex);
    logic signed [TYPE_W:0] t_x;
    logic signed [TYPE_W:0] lim;
    logic                   m;
    t_x = {t[TYPE_W-1], t};
    lim = -{sel[TYPE_W-1], sel};
    if (sel == '0) begin
      m = 1'b1;
    end else if (!sel[TYPE_W-1]) begin
      m = ex ? (t != sel) : (t == sel);
    end else begin
      m = (t_x <= lim);
    end
    return m;
  endfunction

  logic [NUM_QUEUES-1:0] open_mask;

  mqb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .open_mask_o (open_mask)
  );

  logic [2:0]               state_q, state_d;
  logic [TOTAL_SLOTS-1:0]   valid_q, valid_d;
  logic [COUNT_W-1:0]       qcount_q [NUM_QUEUES];
  logic [COUNT_W-1:0]       qcount_d [NUM_QUEUES];
  logic [DIDX_W-1:0]        beat_q, beat_d;
  logic                     sslot_hit_q, sslot_hit_d;
  logic [SLOT_W-1:0]        sslot_q, sslot_d;

  logic [SLOT_W-1:0]        fslot_q, fslot_d;
  logic [DIDX_W-1:0]        fidx_q, fidx_d;
  logic [DIDX_W-1:0]        fk_q, fk_d;
  logic [WORD_W-1:0]        fword_q, fword_d;
  logic                     freloc_q, freloc_d;

  logic [QIDX_W-1:0]        rq_q, rq_d;
  logic signed [TYPE_W-1:0] rsel_q, rsel_d;
  logic                     rex_q, rex_d;
  logic                     rtr_q, rtr_d;
  logic [LEN_W-1:0]         rbuf_q, rbuf_d;
  logic [DIDX_W-1:0]        idx_q, idx_d;
  logic                     rd_pend_q;
  logic                     rd_vld_q;
  logic [SLOT_W-1:0]        rd_slot_q;

  logic                     best_hit_q, best_hit_d;
  logic [SLOT_W-1:0]        best_slot_q, best_slot_d;
  logic [DIDX_W-1:0]        best_rank_q, best_rank_d;
  logic signed [TYPE_W-1:0] best_type_q, best_type_d;
  logic [LEN_W-1:0]         best_len_q, best_len_d;

  logic [LEN_W-1:0]         ret_len_q, ret_len_d;
  logic [DIDX_W-1:0]        nw_q, nw_d;
  logic                     pay_pend_q;
  logic [WIDX_W-1:0]        pay_idx_q;

  logic                     res_vld_q, res_vld_d;
  logic [2:0]               res_st_q, res_st_d;
  logic signed [TYPE_W-1:0] res_type_q, res_type_d;
  logic [LEN_W-1:0]         res_len_q, res_len_d;
  logic [WORD_W-1:0]        res_word_q, res_word_d;
  logic                     res_last_q, res_last_d;

  logic                     meta_we;
  logic [SLOT_W-1:0]        meta_waddr;
  meta_t                    meta_wdata;
  logic [SLOT_W-1:0]        meta_raddr;
  meta_t                    meta_rdata;
  logic                     pay_we;
  logic [PADDR_W-1:0]       pay_waddr;
  logic [WORD_W-1:0]        pay_wdata;
  logic [PADDR_W-1:0]       pay_raddr;
  logic [WORD_W-1:0]        pay_rdata;

  mqb_ram #(.Width(META_W), .Depth(TOTAL_SLOTS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  mqb_ram #(.Width(WORD_W), .Depth(TOTAL_SLOTS * SLOT_WORDS)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pay_wdata),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  logic                 accept;
  logic                 ff_found;
  logic [DIDX_W-1:0]    ff_idx;
  logic [SLOT_W-1:0]    ff_slot;
  logic                 eff_hit;
  logic [SLOT_W-1:0]    eff_slot;
  logic                 q_open;
  logic                 q_full;
  logic                 reloc;
  logic [SLOT_W-1:0]    commit_slot;
  logic [COUNT_W:0]     fill_start;
  logic [LEN_W-1:0]     len_clip;
  logic                 cand;
  logic [LEN_W-1:0]     ret_len;
  logic [LEN_W+2:0]     byte_pos;
  logic [WORD_W-1:0]    masked;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[{queue_index_i, DIDX_W'(i)}]) begin
        ff_found = 1'b1;
        ff_idx   = DIDX_W'(i);
      end
    end
  end

  assign ff_slot  = {queue_index_i, ff_idx};
  assign eff_hit  = (beat_q == '0) ? ff_found : sslot_hit_q;
  assign eff_slot = (beat_q == '0) ? ff_slot : sslot_q;
  assign q_open   = open_mask[queue_index_i];
  assign q_full   = qcount_q[queue_index_i] >= COUNT_W'(QUEUE_DEPTH);
  assign reloc    = !(eff_hit && eff_slot[SLOT_W-1:DIDX_W] == queue_index_i
                      && !valid_q[eff_slot]);
  assign commit_slot = reloc ? ff_slot : eff_slot;
  assign fill_start  = reloc ? '0 : ({2'b00, beat_q} + 1'b1);
  assign len_clip    = (byte_length_i > LEN_W'(MAX_MSG_BYTES)) ?
                       LEN_W'(MAX_MSG_BYTES) : byte_length_i;

  assign cand = rd_pend_q && rd_vld_q && sel_match(meta_rdata.msg_type, rsel_q, rex_q)
                && (!best_hit_q || meta_rdata.rank < best_rank_q);

  assign ret_len = (rtr_q && best_len_q > rbuf_q) ? rbuf_q : best_len_q;

  always_comb begin
    byte_pos = {4'b0000, pay_idx_q, 3'b000};
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = ((byte_pos + 10'(b)) < {3'b000, ret_len_q}) ?
                         pay_rdata[b*8 +: 8] : 8'h00;
    end
  end

  assign meta_raddr = {rq_q, idx_q};
  assign pay_raddr  = {best_slot_q, idx_q[WIDX_W-1:0]};

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    qcount_d    = qcount_q;
    beat_d      = beat_q;
    sslot_hit_d = sslot_hit_q;
    sslot_d     = sslot_q;
    fslot_d     = fslot_q;
    fidx_d      = fidx_q;
    fk_d        = fk_q;
    fword_d     = fword_q;
    freloc_d    = freloc_q;
    rq_d        = rq_q;
    rsel_d      = rsel_q;
    rex_d       = rex_q;
    rtr_d       = rtr_q;
    rbuf_d      = rbuf_q;
    idx_d       = idx_q;
    best_hit_d  = best_hit_q;
    best_slot_d = best_slot_q;
    best_rank_d = best_rank_q;
    best_type_d = best_type_q;
    best_len_d  = best_len_q;
    ret_len_d   = ret_len_q;
    nw_d        = nw_q;
    res_vld_d   = 1'b0;
    res_st_d    = res_st_q;
    res_type_d  = res_type_q;
    res_len_d   = res_len_q;
    res_word_d  = res_word_q;
    res_last_d  = res_last_q;
    meta_we     = 1'b0;
    meta_waddr  = rd_slot_q;
    meta_wdata  = meta_rdata;
    pay_we      = 1'b0;
    pay_waddr   = {fslot_q, fidx_q[WIDX_W-1:0]};
    pay_wdata   = (freloc_q && fidx_q == fk_q) ? fword_q : '0;

    if (cand) begin
      best_hit_d  = 1'b1;
      best_slot_d = rd_slot_q;
      best_rank_d = meta_rdata.rank;
      best_type_d = meta_rdata.msg_type;
      best_len_d  = meta_rdata.length;
    end

    if (pay_pend_q) begin
      res_vld_d  = 1'b1;
      res_st_d   = ST_OK;
      res_type_d = best_type_q;
      res_len_d  = ret_len_q;
      res_word_d = masked;
      res_last_d = ({1'b0, pay_idx_q} == nw_q - 1'b1);
    end

    case (state_q)
      S_IDLE: begin
        if (accept && mode_i == MODE_SEND) begin
          if (beat_q == '0) begin
            sslot_hit_d = ff_found;
            sslot_d     = ff_slot;
          end
          if (!beat_q[DIDX_W-1] && eff_hit && !valid_q[eff_slot]) begin
            pay_we    = 1'b1;
            pay_waddr = {eff_slot, beat_q[WIDX_W-1:0]};
            pay_wdata = data_word_i;
          end
          if (beat_q != '1) begin
            beat_d = beat_q + 1'b1;
          end
          if (last_beat_i) begin
            beat_d     = '0;
            res_vld_d  = 1'b1;
            res_type_d = '0;
            res_word_d = '0;
            res_last_d = 1'b1;
            res_len_d  = '0;
            if (!q_open) begin
              res_st_d = ST_NOT_OPEN;
            end else if (q_full || (reloc && !ff_found)) begin
              res_st_d = ST_FULL;
            end else begin
              res_st_d   = ST_OK;
              res_len_d  = len_clip;
              valid_d[commit_slot] = 1'b1;
              qcount_d[queue_index_i] = qcount_q[queue_index_i] + 1'b1;
              meta_we    = 1'b1;
              meta_waddr = commit_slot;
              meta_wdata = '{msg_type: msg_type_i, length: len_clip,
                             rank: qcount_q[queue_index_i][DIDX_W-1:0]};
              fslot_d    = commit_slot;
              fidx_d     = fill_start[DIDX_W-1:0];
              fk_d       = beat_q;
              fword_d    = data_word_i;
              freloc_d   = reloc;
              if (fill_start < (COUNT_W+1)'(SLOT_WORDS)) begin
                state_d = S_FILL;
              end
            end
          end
        end else if (accept) begin
          rq_d       = queue_index_i;
          rsel_d     = msg_type_i;
          rex_d      = except_flag_i;
          rtr_d      = truncate_flag_i;
          rbuf_d     = byte_length_i;
          idx_d      = '0;
          best_hit_d = 1'b0;
          res_type_d = '0;
          res_len_d  = '0;
          res_word_d = '0;
          res_last_d = 1'b1;
          if (!q_open) begin
            res_vld_d = 1'b1;
            res_st_d  = ST_NOT_OPEN;
          end else if (qcount_q[queue_index_i] == '0) begin
            res_vld_d = 1'b1;
            res_st_d  = ST_EMPTY;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_FILL: begin
        pay_we = 1'b1;
        fidx_d = fidx_q + 1'b1;
        if (fidx_q == DIDX_W'(SLOT_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == '1) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        idx_d = '0;
        if (!best_hit_d) begin
          res_vld_d  = 1'b1;
          res_st_d   = ST_NO_MATCH;
          res_type_d = '0;
          res_len_d  = '0;
          res_word_d = '0;
          res_last_d = 1'b1;
          state_d    = S_IDLE;
        end else begin
          valid_d[best_slot_d] = 1'b0;
          qcount_d[rq_q] = qcount_q[rq_q] - 1'b1;
          state_d = S_FIX;
        end
      end
      S_FIX, S_FIX_END: begin
        if (rd_pend_q && rd_vld_q && meta_rdata.rank > best_rank_q) begin
          meta_we         = 1'b1;
          meta_wdata.rank = meta_rdata.rank - 1'b1;
        end
        if (state_q == S_FIX) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == '1) begin
            state_d = S_FIX_END;
          end
        end else begin
          idx_d     = '0;
          ret_len_d = ret_len;
          nw_d      = DIDX_W'((ret_len + 7'd7) >> 3);
          if (ret_len == '0) begin
            res_vld_d  = 1'b1;
            res_st_d   = ST_OK;
            res_type_d = best_type_q;
            res_len_d  = '0;
            res_word_d = '0;
            res_last_d = 1'b1;
            state_d    = S_IDLE;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == nw_q - 1'b1) begin
          state_d = S_OUT_END;
        end
      end
      S_OUT_END: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      qcount_q    <= '{default: '0};
      beat_q      <= '0;
      sslot_hit_q <= 1'b0;
      sslot_q     <= '0;
      rd_pend_q   <= 1'b0;
      pay_pend_q  <= 1'b0;
      best_hit_q  <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      qcount_q    <= qcount_d;
      beat_q      <= beat_d;
      sslot_hit_q <= sslot_hit_d;
      sslot_q     <= sslot_d;
      rd_pend_q   <= (state_q == S_SCAN) || (state_q == S_FIX);
      pay_pend_q  <= (state_q == S_OUT);
      best_hit_q  <= best_hit_d;
      res_vld_q   <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fslot_q     <= fslot_d;
    fidx_q      <= fidx_d;
    fk_q        <= fk_d;
    fword_q     <= fword_d;
    freloc_q    <= freloc_d;
    rq_q        <= rq_d;
    rsel_q      <= rsel_d;
    rex_q       <= rex_d;
    rtr_q       <= rtr_d;
    rbuf_q      <= rbuf_d;
    idx_q       <= idx_d;
    rd_vld_q    <= valid_q[meta_raddr];
    rd_slot_q   <= meta_raddr;
    best_slot_q <= best_slot_d;
    best_rank_q <= best_rank_d;
    best_type_q <= best_type_d;
    best_len_q  <= best_len_d;
    ret_len_q   <= ret_len_d;
    nw_q        <= nw_d;
    pay_idx_q   <= idx_q[WIDX_W-1:0];
    res_st_q    <= res_st_d;
    res_type_q  <= res_type_d;
    res_len_q   <= res_len_d;
    res_word_q  <= res_word_d;
    res_last_q  <= res_last_d;
  end

  assign result_valid_o = res_vld_q;
  assign status_o       = res_st_q;
  assign out_type_o     = res_type_q;
  assign out_length_o   = res_len_q;
  assign out_word_o     = res_word_q;
  assign last_result_o  = res_last_q;

  logic [COUNT_W+QIDX_W-1:0] count_sum;

  always_comb begin
    count_sum = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      count_sum = count_sum + (COUNT_W+QIDX_W)'(qcount_q[q]);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> last_result_o)
    else $error("error result not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_sum))
    else $error("slot valid bits disagree with queue counts");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN_END && !best_hit_d |=> result_valid_o && status_o == ST_NO_MATCH)
    else $error("failed scan gave no status");

endmodule
`default_nettype wire
